// ===== hdl/sorted_key_table_search_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_key_table_search_macros
// Assertion macros used by the checker of the key table search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define SKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SKS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared widths, defaults and control types of the sorted key table search.
// ----------------------------------------------------------------------------
package sks_pkg;

  // key field and position widths
  localparam int TYPE_W = 8;
  localparam int RID_W  = 16;
  localparam int KEY_W  = TYPE_W + RID_W;
  localparam int POS_W  = 9;

  // default table depth
  localparam int CAPACITY_DEF = 256;

  // item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // memory port strobes from the controller
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

// ===== hdl/sks_key_ram.sv =====
// ----------------------------------------------------------------------------
// sks_key_ram
// Key table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sks_key_ram #(
  parameter int CAPACITY = sks_pkg::CAPACITY_DEF,
  parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                    clk,
  input  sks_pkg::ram_ctl_t       ctl,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [sks_pkg::KEY_W-1:0] wr_data,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [sks_pkg::KEY_W-1:0] rd_data
);
  import sks_pkg::*;

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sks_search_ctrl.sv =====
// ----------------------------------------------------------------------------
// sks_search_ctrl
// Sequencer for loads and binary searches over the key table memory.
// ----------------------------------------------------------------------------
module sks_search_ctrl #(
  parameter int CAPACITY = sks_pkg::CAPACITY_DEF,
  parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_mode,
  input  logic [sks_pkg::TYPE_W-1:0] in_type_id,
  input  logic [sks_pkg::RID_W-1:0]  in_resource_id,
  output sks_pkg::ram_ctl_t         ram_ctl,
  output logic [IDX_W-1:0]          wr_addr,
  output logic [sks_pkg::KEY_W-1:0] wr_data,
  output logic [IDX_W-1:0]          rd_addr,
  input  logic [sks_pkg::KEY_W-1:0] rd_data,
  output logic                      res_valid,
  output logic                      res_found,
  output logic [CNT_W-1:0]          res_pos,
  output logic                      res_full
);
  import sks_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_CMP   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             valid_r, valid_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             full_r, full_nxt;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_c;
  logic             accept;

  assign accept  = start && (state_r == ST_IDLE);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[IDX_W:1];

  // next-state and datapath
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    key_nxt     = key_r;
    valid_nxt   = 1'b0;
    found_nxt   = found_r;
    pos_nxt     = pos_r;
    full_nxt    = full_r;
    ram_ctl     = '0;
    rd_addr     = mid_c;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt = {in_type_id, in_resource_id};
          lo_nxt  = '0;
          hi_nxt  = count_r;
          if (in_mode == MODE_LOAD) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_LOAD: begin
        // append unless the table is full
        valid_nxt = 1'b1;
        found_nxt = 1'b0;
        pos_nxt   = count_r;
        state_nxt = ST_IDLE;
        if (count_r < CNT_W'(CAPACITY)) begin
          ram_ctl.wr_en = 1'b1;
          count_nxt     = count_r + CNT_W'(1);
          full_nxt      = 1'b0;
        end else begin
          full_nxt = 1'b1;
        end
      end
      ST_PROBE: begin
        // issue a read at the midpoint, or finish with the insertion point
        if (lo_r < hi_r) begin
          ram_ctl.rd_en = 1'b1;
          mid_nxt       = mid_c;
          state_nxt     = ST_CMP;
        end else begin
          valid_nxt = 1'b1;
          found_nxt = 1'b0;
          full_nxt  = 1'b0;
          pos_nxt   = lo_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP: begin
        // narrow the range on the probed word
        if (key_r < rd_data) begin
          hi_nxt    = CNT_W'(mid_r);
          state_nxt = ST_PROBE;
        end else if (key_r > rd_data) begin
          lo_nxt    = CNT_W'(mid_r) + CNT_W'(1);
          state_nxt = ST_PROBE;
        end else begin
          valid_nxt = 1'b1;
          found_nxt = 1'b1;
          full_nxt  = 1'b0;
          pos_nxt   = CNT_W'(mid_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    full_r  <= full_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign wr_addr   = count_r[IDX_W-1:0];
  assign wr_data   = key_r;
  assign res_valid = valid_r;
  assign res_found = found_r;
  assign res_pos   = pos_r;
  assign res_full  = full_r;

endmodule

// ===== hdl/sorted_key_table_search.sv =====
// Load: an accepted word is written in the LOAD state, then its result strobe is
// registered; no new word is taken while busy. Search: each probe is one memory
// read (PROBE state) and one compare (CMP state) until a match or an empty range.
// Results cannot be stalled; each strobe lasts exactly one cycle.
// Synchronous active-low reset empties the table; memory contents are not
// cleared, entries past the fill count are never read.
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Table of {type, id} keys with append loads and binary search; loads are not sorted.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
  parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [sks_pkg::TYPE_W-1:0] in_type_id,
  input  logic [sks_pkg::RID_W-1:0]  in_resource_id,
  output logic                       out_valid,
  output logic                       out_found,
  output logic [sks_pkg::POS_W-1:0]  out_position,
  output logic                       out_table_full
);
  import sks_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  ram_ctl_t               ram_ctl;
  logic [IDX_W-1:0]       wr_addr;
  logic [KEY_W-1:0]       wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [KEY_W-1:0]       rd_data;
  logic [CNT_W-1:0]       res_pos;
  logic [CNT_W+POS_W-1:0] pos_ext;

  // sequencer
  sks_search_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_type_id     (in_type_id),
    .in_resource_id (in_resource_id),
    .ram_ctl        (ram_ctl),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .res_valid      (out_valid),
    .res_found      (out_found),
    .res_pos        (res_pos),
    .res_full       (out_table_full)
  );

  // key memory
  sks_key_ram #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // report the position in its low bits
  assign pos_ext      = {{POS_W{1'b0}}, res_pos};
  assign out_position = pos_ext[POS_W-1:0];

endmodule

// ===== hdl/sks_checker.sv =====
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks of the key table search, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_table_search_macros.svh"

module sks_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_found,
  input logic out_table_full
);

  // a dropped load never reports a match
  `SKS_ASSERT_IMP(a_found_not_full, clk, rst_n, out_valid, !(out_found && out_table_full))

  // an accepted word keeps the block busy on the next cycle
  `SKS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // a word finishes with a result strobe in the cycle that busy falls
  `SKS_ASSERT_IMP(a_done_strobe, clk, rst_n, $fell(busy), out_valid)

  // results are single-cycle pulses
  `SKS_ASSERT_NXT(a_strobe_pulse, clk, rst_n, out_valid, !out_valid)

endmodule

bind sorted_key_table_search sks_checker u_sks_checker (.*);
